// ===== rtl/wav_riff_header_parser_core_defines.svh =====
// Assertion macros for the WAV header parser core.
// Included by files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef WAV_RIFF_HEADER_PARSER_CORE_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked on every clock edge out of reset
`define WRHP_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("wrhp invariant violated");
// Condition in one cycle implies a condition in the next
`define WRHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wrhp sequence violated");
`else
`define WRHP_ASSERT(label, expr)
`define WRHP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/wrhp_pkg.sv =====
// Shared types, tags, status codes and helper functions for the WAV header parser.
// No dependencies.
package wrhp_pkg;

    // Chunk and file tags, big-endian as received byte by byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Configuration reset values
    localparam logic [31:0] DEFAULT_RATE     = 32'd16000;
    localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
    localparam logic [15:0] DEFAULT_BITS     = 16'd16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS     = 2'd2;

    // Result kinds
    localparam logic KIND_PCM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_MISSING   = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_BAD_FMT   = 3'd5;

    localparam logic [15:0] FMT_PCM = 16'd1;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm_byte;
        logic [2:0]  status;
        logic [31:0] file_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } res_t;

    // Status from what the fmt and data chunks left behind
    function automatic logic [2:0] final_code(
        input logic        seen_fmt,
        input logic        seen_data,
        input logic [15:0] fmt_code,
        input logic [31:0] rate,
        input logic [15:0] chans,
        input logic [15:0] bits,
        input logic [31:0] req_rate,
        input logic [15:0] req_chans,
        input logic [15:0] req_bits
    );
        logic [2:0] code;
        if (!seen_fmt || !seen_data) begin
            code = ST_MISSING;
        end else if (fmt_code != FMT_PCM) begin
            code = ST_NOT_PCM;
        end else if (rate != req_rate || chans != req_chans || bits != req_bits) begin
            code = ST_BAD_FMT;
        end else begin
            code = ST_OK;
        end
        return code;
    endfunction

    function automatic res_t status_rec(
        input logic [2:0]  code,
        input logic [31:0] rate,
        input logic [15:0] chans,
        input logic [15:0] bits,
        input logic [31:0] dlen
    );
        res_t r;
        r.kind          = KIND_STATUS;
        r.pcm_byte      = '0;
        r.status        = code;
        r.file_rate     = rate;
        r.channel_count = chans;
        r.sample_bits   = bits;
        r.data_length   = dlen;
        return r;
    endfunction

endpackage

// ===== rtl/wav_riff_header_parser_core.sv =====
// WAV (RIFF) PCM header parser: byte-wide file input, PCM byte and status output.
// Depends on wrhp_pkg and wav_riff_header_parser_core_defines.svh.
//
// Usage:
//   s_ channel carries one file byte per transfer, with s_end_of_file set on
//   the last byte of a file. m_ channel returns PCM bytes of the data chunk
//   (kind 0) and one final status record per file (kind 1).
//   cfg_we/cfg_index/cfg_wdata write the required rate, channels and bits;
//   write them only while no file is in flight.
// Timing:
//   Each byte is parsed in the cycle it is accepted; its results appear on the
//   m_ channel from the next cycle. One byte per cycle is sustained while the queue has room. A byte
//   can cause up to two results (last PCM byte plus status), which go into a
//   four-entry result queue; s_ready is high while the queue has two free
//   entries, so the queue depth sets how long input keeps flowing while the
//   receiver stalls.
// Reset:
//   The parser waits for a RIFF tag, the queue is empty and the required
//   format registers return to 16000 Hz, 1 channel, 16 bits. After the byte
//   flagged end of file the parser rearms for a new file on its own.
`include "wav_riff_header_parser_core_defines.svh"

module wav_riff_header_parser_core
    import wrhp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    // file bytes in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_file_byte,
    input  logic                 s_end_of_file,
    // results out
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [7:0]           m_pcm_byte,
    output logic [2:0]           m_status,
    output logic [31:0]          m_sample_rate,
    output logic [15:0]          m_channel_count,
    output logic [15:0]          m_sample_bits,
    output logic [31:0]          m_data_length
);

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_CID   = 4'd3,
        PH_CSIZE = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_DATA  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic [31:0] req_rate_reg;
    logic [15:0] req_chans_reg;
    logic [15:0] req_bits_reg;

    // parser state
    phase_t      phase_reg,          phase_next;
    logic [31:0] byte_count_reg,     byte_count_next;
    logic [31:0] word_shift_reg,     word_shift_next;
    logic [31:0] chunk_tag_reg,      chunk_tag_next;
    logic        seen_fmt_reg,       seen_fmt_next;
    logic        seen_data_reg,      seen_data_next;
    logic [15:0] format_code_reg,    format_code_next;
    logic [31:0] rate_value_reg,     rate_value_next;
    logic [15:0] channels_value_reg, channels_value_next;
    logic [15:0] bits_value_reg,     bits_value_next;
    logic [31:0] data_size_reg,      data_size_next;

    // result queue
    res_t             res_fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;

    logic        accept;
    logic        pop;
    logic        pcm_emit;
    logic        status_emit;
    logic        st_hit;
    logic [2:0]  st_code;
    logic [2:0]  eof_code;
    logic [31:0] tag_shift;
    logic [31:0] cnt_inc;
    logic [31:0] cnt_dec;
    logic [1:0]  n_push;
    res_t        pcm_rec;
    res_t        stat_rec;
    res_t        push0_rec;
    res_t        out_rec;

    assign accept    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign s_ready   = (fifo_cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_valid   = (fifo_cnt_reg != '0);
    assign tag_shift = {chunk_tag_reg[23:0], s_file_byte};
    assign cnt_inc   = byte_count_reg + 32'd1;
    assign cnt_dec   = (byte_count_reg != '0) ? (byte_count_reg - 32'd1) : byte_count_reg;

    // Parse one byte: phase step, early status, then end-of-file wrap-up
    always_comb begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        word_shift_next     = word_shift_reg;
        chunk_tag_next      = chunk_tag_reg;
        seen_fmt_next       = seen_fmt_reg;
        seen_data_next      = seen_data_reg;
        format_code_next    = format_code_reg;
        rate_value_next     = rate_value_reg;
        channels_value_next = channels_value_reg;
        bits_value_next     = bits_value_reg;
        data_size_next      = data_size_reg;
        pcm_emit            = 1'b0;
        status_emit         = 1'b0;
        st_hit              = 1'b0;
        st_code             = ST_OK;
        eof_code            = ST_OK;
        stat_rec            = status_rec(ST_OK, '0, '0, '0, '0);

        if (accept) begin
            unique case (phase_reg)
                PH_RIFF: begin
                    chunk_tag_next  = tag_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd4) begin
                        if (tag_shift != TAG_RIFF) begin
                            st_hit  = 1'b1;
                            st_code = ST_NOT_RIFF;
                        end else begin
                            phase_next      = PH_RSIZE;
                            byte_count_next = '0;
                            chunk_tag_next  = '0;
                        end
                    end
                end
                PH_RSIZE: begin
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd4) begin
                        phase_next      = PH_WAVE;
                        byte_count_next = '0;
                        chunk_tag_next  = '0;
                    end
                end
                PH_WAVE: begin
                    chunk_tag_next  = tag_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd4) begin
                        if (tag_shift != TAG_WAVE) begin
                            st_hit  = 1'b1;
                            st_code = ST_NOT_WAVE;
                        end else begin
                            phase_next      = PH_CID;
                            byte_count_next = '0;
                            chunk_tag_next  = '0;
                        end
                    end
                end
                PH_CID: begin
                    chunk_tag_next  = tag_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd4) begin
                        phase_next      = PH_CSIZE;
                        byte_count_next = '0;
                        word_shift_next = '0;
                    end
                end
                PH_CSIZE: begin
                    // little-endian size, one byte lane per count
                    word_shift_next = word_shift_reg
                                    | ({24'd0, s_file_byte} << {byte_count_reg[1:0], 3'b000});
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd4) begin
                        byte_count_next = '0;
                        if (chunk_tag_reg == TAG_FMT) begin
                            format_code_next    = '0;
                            channels_value_next = '0;
                            rate_value_next     = '0;
                            bits_value_next     = '0;
                            phase_next          = PH_FMT;
                        end else if (chunk_tag_reg == TAG_DATA) begin
                            data_size_next = word_shift_next;
                            if (word_shift_next == '0) begin
                                seen_data_next = 1'b1;
                                chunk_tag_next = '0;
                                if (seen_fmt_reg) begin
                                    st_hit = 1'b1;
                                end else begin
                                    phase_next = PH_CID;
                                end
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end else if (word_shift_next == '0) begin
                            chunk_tag_next = '0;
                            if (seen_fmt_reg && seen_data_reg) begin
                                st_hit = 1'b1;
                            end else begin
                                phase_next = PH_CID;
                            end
                        end else begin
                            phase_next      = PH_SKIP;
                            byte_count_next = word_shift_next;
                        end
                    end
                end
                PH_FMT: begin
                    // fixed 16-byte field layout
                    case (byte_count_reg[3:0])
                        4'd0:  format_code_next[7:0]     = s_file_byte;
                        4'd1:  format_code_next[15:8]    = s_file_byte;
                        4'd2:  channels_value_next[7:0]  = s_file_byte;
                        4'd3:  channels_value_next[15:8] = s_file_byte;
                        4'd4:  rate_value_next[7:0]      = s_file_byte;
                        4'd5:  rate_value_next[15:8]     = s_file_byte;
                        4'd6:  rate_value_next[23:16]    = s_file_byte;
                        4'd7:  rate_value_next[31:24]    = s_file_byte;
                        4'd14: bits_value_next[7:0]      = s_file_byte;
                        4'd15: bits_value_next[15:8]     = s_file_byte;
                        default: ;
                    endcase
                    byte_count_next = cnt_inc;
                    if (cnt_inc == 32'd16) begin
                        seen_fmt_next = 1'b1;
                        if (seen_data_reg) begin
                            st_hit = 1'b1;
                        end else if (word_shift_reg > 32'd16) begin
                            phase_next      = PH_SKIP;
                            byte_count_next = word_shift_reg - 32'd16;
                        end else begin
                            phase_next      = PH_CID;
                            byte_count_next = '0;
                            chunk_tag_next  = '0;
                        end
                    end
                end
                PH_SKIP: begin
                    byte_count_next = cnt_dec;
                    if (cnt_dec == '0) begin
                        chunk_tag_next = '0;
                        if (seen_fmt_reg && seen_data_reg) begin
                            st_hit = 1'b1;
                        end else begin
                            phase_next = PH_CID;
                        end
                    end
                end
                PH_DATA: begin
                    pcm_emit        = 1'b1;
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= data_size_reg) begin
                        seen_data_next  = 1'b1;
                        byte_count_next = '0;
                        chunk_tag_next  = '0;
                        if (seen_fmt_reg) begin
                            st_hit = 1'b1;
                        end else begin
                            phase_next = PH_CID;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase

            // status raised by the byte itself (bad tag or both chunks done)
            if (st_hit) begin
                if (st_code == ST_OK) begin
                    st_code = final_code(seen_fmt_next, seen_data_next, format_code_next,
                                         rate_value_next, channels_value_next,
                                         bits_value_next, req_rate_reg, req_chans_reg,
                                         req_bits_reg);
                end
                stat_rec    = status_rec(st_code, rate_value_next, channels_value_next,
                                         bits_value_next, data_size_next);
                status_emit = 1'b1;
                phase_next  = PH_DONE;
            end

            // end of file: close out a pending file, then rearm
            if (s_end_of_file) begin
                if (phase_next != PH_DONE) begin
                    if (phase_next == PH_RIFF) begin
                        eof_code = ST_NOT_RIFF;
                    end else if (phase_next == PH_RSIZE || phase_next == PH_WAVE) begin
                        eof_code = ST_NOT_WAVE;
                    end else begin
                        if (phase_next == PH_CSIZE) begin
                            if (chunk_tag_next == TAG_FMT) begin
                                format_code_next    = '0;
                                channels_value_next = '0;
                                rate_value_next     = '0;
                                bits_value_next     = '0;
                                seen_fmt_next       = 1'b1;
                            end else if (chunk_tag_next == TAG_DATA) begin
                                data_size_next = word_shift_next;
                                seen_data_next = 1'b1;
                            end
                        end else if (phase_next == PH_FMT) begin
                            seen_fmt_next = 1'b1;
                        end else if (phase_next == PH_DATA) begin
                            seen_data_next = 1'b1;
                        end
                        eof_code = final_code(seen_fmt_next, seen_data_next, format_code_next,
                                              rate_value_next, channels_value_next,
                                              bits_value_next, req_rate_reg, req_chans_reg,
                                              req_bits_reg);
                    end
                    stat_rec    = status_rec(eof_code, rate_value_next, channels_value_next,
                                             bits_value_next, data_size_next);
                    status_emit = 1'b1;
                end
                phase_next          = PH_RIFF;
                byte_count_next     = '0;
                word_shift_next     = '0;
                chunk_tag_next      = '0;
                seen_fmt_next       = 1'b0;
                seen_data_next      = 1'b0;
                format_code_next    = '0;
                rate_value_next     = '0;
                channels_value_next = '0;
                bits_value_next     = '0;
                data_size_next      = '0;
            end
        end
    end

    // Result queue bookkeeping: PCM byte first, status after it
    always_comb begin
        pcm_rec          = status_rec(ST_OK, '0, '0, '0, '0);
        pcm_rec.kind     = KIND_PCM;
        pcm_rec.pcm_byte = s_file_byte;
        push0_rec        = pcm_emit ? pcm_rec : stat_rec;
        n_push           = {1'b0, pcm_emit} + {1'b0, status_emit};
        wr_ptr_next      = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next      = rd_ptr_reg + PTR_W'(pop);
        fifo_cnt_next    = fifo_cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    // State, configuration and queue registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_rate_reg       <= DEFAULT_RATE;
            req_chans_reg      <= DEFAULT_CHANNELS;
            req_bits_reg       <= DEFAULT_BITS;
            phase_reg          <= PH_RIFF;
            byte_count_reg     <= '0;
            word_shift_reg     <= '0;
            chunk_tag_reg      <= '0;
            seen_fmt_reg       <= 1'b0;
            seen_data_reg      <= 1'b0;
            format_code_reg    <= '0;
            rate_value_reg     <= '0;
            channels_value_reg <= '0;
            bits_value_reg     <= '0;
            data_size_reg      <= '0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            fifo_cnt_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_RATE:     req_rate_reg  <= cfg_wdata;
                    CFG_CHANNELS: req_chans_reg <= cfg_wdata[15:0];
                    CFG_BITS:     req_bits_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            word_shift_reg     <= word_shift_next;
            chunk_tag_reg      <= chunk_tag_next;
            seen_fmt_reg       <= seen_fmt_next;
            seen_data_reg      <= seen_data_next;
            format_code_reg    <= format_code_next;
            rate_value_reg     <= rate_value_next;
            channels_value_reg <= channels_value_next;
            bits_value_reg     <= bits_value_next;
            data_size_reg      <= data_size_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            fifo_cnt_reg       <= fifo_cnt_next;
            if (n_push != 2'd0) begin
                res_fifo_reg[wr_ptr_reg] <= push0_rec;
            end
            if (n_push == 2'd2) begin
                res_fifo_reg[wr_ptr_reg + PTR_W'(1)] <= stat_rec;
            end
        end
    end

    // Output side
    assign out_rec         = res_fifo_reg[rd_ptr_reg];
    assign m_kind          = out_rec.kind;
    assign m_pcm_byte      = out_rec.pcm_byte;
    assign m_status        = out_rec.status;
    assign m_sample_rate   = out_rec.file_rate;
    assign m_channel_count = out_rec.channel_count;
    assign m_sample_bits   = out_rec.sample_bits;
    assign m_data_length   = out_rec.data_length;

    // Checks
    `WRHP_ASSERT(a_fifo_bound, fifo_cnt_reg <= CNT_W'(FIFO_DEPTH))
    `WRHP_ASSERT(a_fmt_index, phase_reg != PH_FMT || byte_count_reg < 32'd16)
    `WRHP_ASSERT(a_pcm_clean, !m_valid || m_kind == KIND_STATUS || (m_status == ST_OK && m_data_length == '0 && m_sample_rate == '0))
    `WRHP_ASSERT_NEXT(a_eof_rearm, accept && s_end_of_file, phase_reg == PH_RIFF && byte_count_reg == '0 && !seen_fmt_reg && !seen_data_reg)

endmodule

// ===== test/wav_parse_checker.sv =====
// Checker for the WAV header parser: predicts PCM bytes and status records per accepted file byte
// and compares them with the result channel. Depends on wrhp_pkg.
module wav_parse_checker
    import wrhp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_file_byte,
    input  logic                 s_end_of_file,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_kind,
    input  logic [7:0]           m_pcm_byte,
    input  logic [2:0]           m_status,
    input  logic [31:0]          m_sample_rate,
    input  logic [15:0]          m_channel_count,
    input  logic [15:0]          m_sample_bits,
    input  logic [31:0]          m_data_length,
    output int                   fail_count,
    output int                   pending
);

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_TAG, PH_CHUNK_SIZE,
        PH_FMT_BODY, PH_SKIP_BODY, PH_DATA_BODY, PH_DONE
    } parse_phase_t;

    // required format
    logic [31:0]  req_rate;
    logic [15:0]  req_chans;
    logic [15:0]  req_bits;

    // parser state of the file in flight
    parse_phase_t parse_phase;
    logic [31:0]  byte_cnt;
    logic [31:0]  size_word;
    logic [31:0]  tag_word;
    logic         fmt_seen;
    logic         data_seen;
    logic [15:0]  fmt_code;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_chans;
    logic [15:0]  fmt_bits;
    logic [31:0]  data_len;

    res_t         expected_results[$];
    res_t         got_result;
    res_t         want_result;
    int           errors = 0;

    function automatic void clear_parse();
        parse_phase = PH_RIFF_TAG;
        byte_cnt    = '0;
        size_word   = '0;
        tag_word    = '0;
        fmt_seen    = 1'b0;
        data_seen   = 1'b0;
        fmt_code    = '0;
        fmt_rate    = '0;
        fmt_chans   = '0;
        fmt_bits    = '0;
        data_len    = '0;
    endfunction

    function automatic logic [2:0] verdict_code();
        logic [2:0] code;
        if (!fmt_seen || !data_seen) begin
            code = ST_MISSING;
        end else if (fmt_code != FMT_PCM) begin
            code = ST_NOT_PCM;
        end else if (fmt_rate != req_rate || fmt_chans != req_chans || fmt_bits != req_bits) begin
            code = ST_BAD_FMT;
        end else begin
            code = ST_OK;
        end
        return code;
    endfunction

    // Returns 1 when both fmt and data are in, else goes back to the next chunk tag
    function automatic logic close_chunk();
        byte_cnt = '0;
        tag_word = '0;
        if (fmt_seen && data_seen) begin
            return 1'b1;
        end
        parse_phase = PH_CHUNK_TAG;
        return 1'b0;
    endfunction

    function automatic void clear_fmt_fields();
        fmt_code  = '0;
        fmt_chans = '0;
        fmt_rate  = '0;
        fmt_bits  = '0;
    endfunction

    function automatic void queue_pcm(logic [7:0] b);
        res_t r;
        r          = '0;
        r.kind     = KIND_PCM;
        r.pcm_byte = b;
        expected_results.push_back(r);
    endfunction

    function automatic void queue_status(logic [2:0] code);
        res_t r;
        r               = '0;
        r.kind          = KIND_STATUS;
        r.status        = code;
        r.file_rate     = fmt_rate;
        r.channel_count = fmt_chans;
        r.sample_bits   = fmt_bits;
        r.data_length   = data_len;
        expected_results.push_back(r);
    endfunction

    // One file byte through the parser
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic        finished;
        logic [2:0]  code;
        logic [15:0] b16;
        logic [31:0] b32;
        finished = 1'b0;
        code     = ST_OK;
        b16      = {8'h00, b};
        b32      = {24'h000000, b};
        case (parse_phase)
            PH_RIFF_TAG: begin
                tag_word = {tag_word[23:0], b};
                byte_cnt = byte_cnt + 1;
                if (byte_cnt == 4) begin
                    if (tag_word != TAG_RIFF) begin
                        finished = 1'b1;
                        code     = ST_NOT_RIFF;
                    end else begin
                        parse_phase = PH_RIFF_SIZE;
                        byte_cnt    = '0;
                        tag_word    = '0;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                byte_cnt = byte_cnt + 1;
                if (byte_cnt == 4) begin
                    parse_phase = PH_WAVE_TAG;
                    byte_cnt    = '0;
                    tag_word    = '0;
                end
            end
            PH_WAVE_TAG: begin
                tag_word = {tag_word[23:0], b};
                byte_cnt = byte_cnt + 1;
                if (byte_cnt == 4) begin
                    if (tag_word != TAG_WAVE) begin
                        finished = 1'b1;
                        code     = ST_NOT_WAVE;
                    end else begin
                        parse_phase = PH_CHUNK_TAG;
                        byte_cnt    = '0;
                        tag_word    = '0;
                    end
                end
            end
            PH_CHUNK_TAG: begin
                tag_word = {tag_word[23:0], b};
                byte_cnt = byte_cnt + 1;
                if (byte_cnt == 4) begin
                    parse_phase = PH_CHUNK_SIZE;
                    byte_cnt    = '0;
                    size_word   = '0;
                end
            end
            PH_CHUNK_SIZE: begin
                // little-endian chunk size
                size_word = size_word | (b32 << (8 * byte_cnt[1:0]));
                byte_cnt  = byte_cnt + 1;
                if (byte_cnt == 4) begin
                    byte_cnt = '0;
                    if (tag_word == TAG_FMT) begin
                        clear_fmt_fields();
                        parse_phase = PH_FMT_BODY;
                    end else if (tag_word == TAG_DATA) begin
                        data_len = size_word;
                        if (data_len == 0) begin
                            data_seen = 1'b1;
                            if (close_chunk()) begin
                                finished = 1'b1;
                                code     = verdict_code();
                            end
                        end else begin
                            parse_phase = PH_DATA_BODY;
                        end
                    end else if (size_word == 0) begin
                        if (close_chunk()) begin
                            finished = 1'b1;
                            code     = verdict_code();
                        end
                    end else begin
                        parse_phase = PH_SKIP_BODY;
                        byte_cnt    = size_word;
                    end
                end
            end
            PH_FMT_BODY: begin
                // code, channels, rate, byte rate, block align, bits
                if (byte_cnt < 2) begin
                    fmt_code = fmt_code | (b16 << (8 * byte_cnt));
                end else if (byte_cnt < 4) begin
                    fmt_chans = fmt_chans | (b16 << (8 * (byte_cnt - 2)));
                end else if (byte_cnt < 8) begin
                    fmt_rate = fmt_rate | (b32 << (8 * (byte_cnt - 4)));
                end else if (byte_cnt >= 14 && byte_cnt < 16) begin
                    fmt_bits = fmt_bits | (b16 << (8 * (byte_cnt - 14)));
                end
                byte_cnt = byte_cnt + 1;
                if (byte_cnt == 16) begin
                    fmt_seen = 1'b1;
                    if (data_seen) begin
                        finished = 1'b1;
                        code     = verdict_code();
                    end else if (size_word > 16) begin
                        parse_phase = PH_SKIP_BODY;
                        byte_cnt    = size_word - 16;
                    end else begin
                        void'(close_chunk());
                    end
                end
            end
            PH_SKIP_BODY: begin
                if (byte_cnt > 0) begin
                    byte_cnt = byte_cnt - 1;
                end
                if (byte_cnt == 0) begin
                    if (close_chunk()) begin
                        finished = 1'b1;
                        code     = verdict_code();
                    end
                end
            end
            PH_DATA_BODY: begin
                queue_pcm(b);
                byte_cnt = byte_cnt + 1;
                if (byte_cnt >= data_len) begin
                    data_seen = 1'b1;
                    if (close_chunk()) begin
                        finished = 1'b1;
                        code     = verdict_code();
                    end
                end
            end
            default: begin
                parse_phase = PH_DONE;
            end
        endcase

        if (finished) begin
            queue_status(code);
            parse_phase = PH_DONE;
        end

        // end of file: report what was gathered unless already reported, then rearm
        if (eof) begin
            if (parse_phase != PH_DONE) begin
                if (parse_phase == PH_RIFF_TAG) begin
                    code = ST_NOT_RIFF;
                end else if (parse_phase == PH_RIFF_SIZE || parse_phase == PH_WAVE_TAG) begin
                    code = ST_NOT_WAVE;
                end else begin
                    if (parse_phase == PH_CHUNK_SIZE) begin
                        if (tag_word == TAG_FMT) begin
                            clear_fmt_fields();
                            fmt_seen = 1'b1;
                        end else if (tag_word == TAG_DATA) begin
                            data_len  = size_word;
                            data_seen = 1'b1;
                        end
                    end else if (parse_phase == PH_FMT_BODY) begin
                        fmt_seen = 1'b1;
                    end else if (parse_phase == PH_DATA_BODY) begin
                        data_seen = 1'b1;
                    end
                    code = verdict_code();
                end
                queue_status(code);
            end
            clear_parse();
        end
    endtask

    // Track config, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_rate  = DEFAULT_RATE;
            req_chans = DEFAULT_CHANNELS;
            req_bits  = DEFAULT_BITS;
            clear_parse();
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RATE:     req_rate  = cfg_wdata;
                    CFG_CHANNELS: req_chans = cfg_wdata[15:0];
                    CFG_BITS:     req_bits  = cfg_wdata[15:0];
                    default:      ;
                endcase
            end
            if (s_valid && s_ready) begin
                parse_byte(s_file_byte, s_end_of_file);
            end
            if (m_valid && m_ready) begin
                got_result = {m_kind, m_pcm_byte, m_status, m_sample_rate,
                              m_channel_count, m_sample_bits, m_data_length};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result, want none: kind=%0d pcm=%02h status=%0d rate=%0d",
                                 m_kind, m_pcm_byte, m_status, m_sample_rate);
                    end
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result !== want_result) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch want: kind=%0d pcm=%02h st=%0d rate=%0d ch=%0d bits=%0d len=%0d",
                                     want_result.kind, want_result.pcm_byte, want_result.status,
                                     want_result.file_rate, want_result.channel_count,
                                     want_result.sample_bits, want_result.data_length);
                            $display("mismatch got:  kind=%0d pcm=%02h st=%0d rate=%0d ch=%0d bits=%0d len=%0d",
                                     m_kind, m_pcm_byte, m_status, m_sample_rate,
                                     m_channel_count, m_sample_bits, m_data_length);
                        end
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the WAV header parser regression: clock, reset, file byte stimulus, config writes
// and receiver stalls. Depends on wrhp_pkg, wav_parse_checker and wav_riff_header_parser_core.
module testbench;
    import wrhp_pkg::*;

    localparam int RANDOM_BYTES  = 1800;
    localparam int CONFIG_ROUNDS = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [31:0]          cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_file_byte     = '0;
    logic                 s_end_of_file   = 1'b0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_kind;
    logic [7:0]           m_pcm_byte;
    logic [2:0]           m_status;
    logic [31:0]          m_sample_rate;
    logic [15:0]          m_channel_count;
    logic [15:0]          m_sample_bits;
    logic [31:0]          m_data_length;

    int                   fail_count;
    int                   pending;

    // stimulus state
    logic [7:0]           file_q[$];
    logic [31:0]          cur_rate  = DEFAULT_RATE;
    logic [15:0]          cur_chans = DEFAULT_CHANNELS;
    logic [15:0]          cur_bits  = DEFAULT_BITS;
    int                   bytes_sent = 0;
    int                   gap_pct    = 0;
    bit                   calm       = 1'b0;
    int                   cycle_no   = 0;
    int                   stall_left = 0;
    int                   stall_pct  = 0;

    wav_riff_header_parser_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pcm_byte      (m_pcm_byte),
        .m_status        (m_status),
        .m_sample_rate   (m_sample_rate),
        .m_channel_count (m_channel_count),
        .m_sample_bits   (m_sample_bits),
        .m_data_length   (m_data_length)
    );

    wav_parse_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pcm_byte      (m_pcm_byte),
        .m_status        (m_status),
        .m_sample_rate   (m_sample_rate),
        .m_channel_count (m_channel_count),
        .m_sample_bits   (m_sample_bits),
        .m_data_length   (m_data_length),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: stall bursts of random length, stall rate redrawn from a fixed set of percentages
    always @(posedge aclk) begin
        if (cycle_no % 128 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                2: stall_pct <= 25;
                default: stall_pct <= 50;
            endcase
        end
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 14) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One byte transfer, then maybe an idle burst
    task automatic send_byte(input logic [7:0] b, input logic eof);
        s_valid       <= 1'b1;
        s_file_byte   <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Send the first cut bytes of the built file, end of file on the last one sent
    task automatic send_file(input int cut);
        int n;
        n = (cut < file_q.size()) ? cut : file_q.size();
        for (int i = 0; i < n; i++) begin
            send_byte(file_q[i], i == n - 1);
        end
        file_q.delete();
    endtask

    // Hold input until every predicted result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // New required format, written only with the parser idle
    task automatic set_config(input logic [31:0] rate, input logic [31:0] chans,
                              input logic [31:0] bits);
        drain_results();
        repeat (8) @(posedge aclk);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_CHANNELS, chans);
        write_reg(CFG_BITS, bits);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_rate  = rate;
        cur_chans = chans[15:0];
        cur_bits  = bits[15:0];
    endtask

    task automatic put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) begin
            file_q.push_back(t[8*i +: 8]);
        end
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            file_q.push_back(v[8*i +: 8]);
        end
    endtask

    // fmt chunk: mostly 16 bytes, sometimes excess or a short declared size
    task automatic put_fmt_chunk();
        logic [31:0] declared;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            declared = 16;
        end else if (r < 9) begin
            declared = $urandom_range(17, 21);
        end else begin
            declared = $urandom_range(0, 15);
        end
        code  = ($urandom_range(0, 7) != 0) ? FMT_PCM : 16'($urandom_range(0, 65535));
        chans = ($urandom_range(0, 3) != 0) ? cur_chans : 16'($urandom_range(0, 65535));
        rate  = ($urandom_range(0, 3) != 0) ? cur_rate : $urandom;
        bits  = ($urandom_range(0, 3) != 0) ? cur_bits : 16'($urandom_range(0, 65535));
        put_tag(TAG_FMT);
        put_le(declared, 4);
        put_le({16'h0000, code}, 2);
        put_le({16'h0000, chans}, 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le({16'h0000, bits}, 2);
        if (declared > 16) begin
            repeat (declared - 16) file_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic put_data_chunk(input logic [31:0] declared, input int n);
        put_tag(TAG_DATA);
        put_le(declared, 4);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_junk_chunk(input logic [31:0] declared, input int n);
        put_tag($urandom);
        put_le(declared, 4);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic int rand_data_len();
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
    endfunction

    initial begin
        int round_end;
        int calm_point;
        int file_no;
        int pick;
        int shape;
        int n;
        int cut;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short and broken headers, extreme byte values
        file_q.push_back(8'h00);
        send_file(1);
        put_tag(32'h5249_46FF);
        send_file(4);
        put_tag(TAG_RIFF);
        file_q.push_back(8'hFF);
        send_file(5);
        put_tag(TAG_RIFF);
        put_le(32'hFFFF_FFFF, 4);
        put_tag(TAG_WAVE ^ 32'h0000_0001);
        send_file(12);

        // random files, one config setting per round
        calm_point = bytes_sent + RANDOM_BYTES * 9 / 10;
        file_no    = 0;
        for (int cfg_round = 0; cfg_round < CONFIG_ROUNDS; cfg_round++) begin
            case (cfg_round)
                1: set_config(32'h0, 32'h0, 32'h0);
                2: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: set_config(32'd44100, {16'($urandom_range(0, 65535)), 16'd2},
                              {16'($urandom_range(0, 65535)), 16'd16});
                4: set_config($urandom, $urandom_range(1, 8), $urandom_range(1, 4) * 8);
                default: ;
            endcase
            round_end = bytes_sent + RANDOM_BYTES / CONFIG_ROUNDS;
            while (bytes_sent < round_end) begin
                file_no++;
                if (bytes_sent >= calm_point) begin
                    calm = 1'b1;
                end
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                // now and then let the result side run dry before the next file
                if (file_no % 10 == 3) begin
                    drain_results();
                end

                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // noise
                    repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(0, 255)));
                end else if (pick == 1) begin
                    // corrupted RIFF or WAVE tag
                    if ($urandom_range(0, 1) == 0) begin
                        put_tag(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
                    end else begin
                        put_tag(TAG_RIFF);
                        put_le($urandom, 4);
                        put_tag(TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
                    end
                    repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    // well-formed header with random chunk layout
                    put_tag(TAG_RIFF);
                    put_le($urandom, 4);
                    put_tag(TAG_WAVE);
                    if ($urandom_range(0, 3) == 0) begin
                        n = $urandom_range(0, 5);
                        put_junk_chunk(n, n);
                    end
                    shape = $urandom_range(0, 13);
                    case (shape)
                        0: begin
                            // huge data chunk cut short by end of file
                            if ($urandom_range(0, 1) == 0) begin
                                put_fmt_chunk();
                            end
                            put_data_chunk(32'hFFFF_FFF0 | $urandom_range(0, 15),
                                           $urandom_range(1, 6));
                        end
                        1: begin
                            // huge unknown chunk cut short by end of file
                            if ($urandom_range(0, 1) == 0) begin
                                put_fmt_chunk();
                            end
                            put_junk_chunk(32'h8000_0000 | $urandom, $urandom_range(1, 6));
                        end
                        2, 3, 4: begin
                            put_fmt_chunk();
                            n = rand_data_len();
                            put_data_chunk(n, n);
                        end
                        5, 6, 7: begin
                            n = rand_data_len();
                            put_data_chunk(n, n);
                            put_fmt_chunk();
                        end
                        8, 9: begin
                            put_fmt_chunk();
                            n = $urandom_range(0, 5);
                            put_junk_chunk(n, n);
                            n = rand_data_len();
                            put_data_chunk(n, n);
                        end
                        10, 11: begin
                            // two data chunks before fmt, the second one counts
                            n = rand_data_len();
                            put_data_chunk(n, n);
                            n = rand_data_len();
                            put_data_chunk(n, n);
                            put_fmt_chunk();
                        end
                        default: begin
                            // only one of the two chunks
                            if ($urandom_range(0, 1) == 0) begin
                                put_fmt_chunk();
                            end else begin
                                n = rand_data_len();
                                put_data_chunk(n, n);
                            end
                            n = $urandom_range(0, 5);
                            put_junk_chunk(n, n);
                        end
                    endcase
                    // bytes after the last chunk, ignored once parsing is done
                    if (shape > 1 && $urandom_range(0, 2) == 0) begin
                        repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
                    end
                end

                // truncate about a quarter of the files anywhere
                cut = file_q.size();
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, file_q.size());
                end
                send_file(cut);
            end
        end

        // wind down and give the verdict
        calm = 1'b1;
        drain_results();
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wrhp_pkg.sv
rtl/wav_riff_header_parser_core.sv
test/wav_parse_checker.sv
test/testbench.sv
